// ----- design/dve_pkg.sv -----
// ----------------------------------------------------------------------------
// dve_pkg: shared types and constants for the distinct value estimator
// Holds the case codes, the control word that travels with each item through
// the pipeline, default parameter values and width helper functions.
// ----------------------------------------------------------------------------
package dve_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int POP_BITS_DEF    = 40;
   localparam int WEIGHT_BITS     = 16;
   localparam int CASE_BITS       = 3;

   typedef enum logic [CASE_BITS-1:0] {
      CASE_INVALID     = 3'd0,
      CASE_FULL_COVER  = 3'd1,
      CASE_ALL_SINGLE  = 3'd2,
      CASE_NO_SINGLE   = 3'd3,
      CASE_ESTIMATOR   = 3'd4
   } case_type;

   typedef struct packed {
      logic     valid;
      case_type code;
   } ctl_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Width of the estimator denominator (n - f1) * N + f1 * n.
   function automatic int den_bits(input int s, input int p);
      return max_int(s + p, 2 * s) + 1;
   endfunction

endpackage

// ----- design/dve_front.sv -----
// ----------------------------------------------------------------------------
// dve_front: sample decode and case selection
// Three stages: clamp the sample counts, form the small products, then derive
// the population row count and pick the case that decides the estimate.
// ----------------------------------------------------------------------------
module dve_front #(
   parameter int SAMPLE_BITS = dve_pkg::SAMPLE_BITS_DEF,
   parameter int POP_BITS    = dve_pkg::POP_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [SAMPLE_BITS-1:0]            rows,
   input  logic [SAMPLE_BITS-1:0]            nulls,
   input  logic [SAMPLE_BITS-1:0]            distinct,
   input  logic [SAMPLE_BITS-1:0]            singletons,
   input  logic [dve_pkg::WEIGHT_BITS-1:0]   weight,
   input  logic [POP_BITS-1:0]               pop,
   output dve_pkg::ctl_type                  ctl_o,
   output logic [POP_BITS-1:0]               big_n_o,
   output logic [SAMPLE_BITS-1:0]            d_o,
   output logic [2*SAMPLE_BITS-1:0]          nd_o,
   output logic [SAMPLE_BITS-1:0]            nmf_o,
   output logic [2*SAMPLE_BITS-1:0]          f1n_o
);
   import dve_pkg::*;

   localparam int S     = SAMPLE_BITS;
   localparam int P     = POP_BITS;
   localparam int W     = WEIGHT_BITS;
   localparam int NDW   = 2 * S;
   localparam int WN_W  = W + S;
   localparam int EXT_W = max_int(WN_W, P);
   localparam int CMP_W = max_int(S, P);
   localparam logic [P-1:0] POP_MAX = '1;

   // Stage A: clamped counts.
   logic          a_valid_ff, a_valid_in;
   logic [S-1:0]  a_n_ff, a_n_in;
   logic [S-1:0]  a_d_ff, a_d_in;
   logic [S-1:0]  a_f1_ff, a_f1_in;
   logic [W-1:0]  a_w_ff, a_w_in;
   logic          a_w_one_ff, a_w_one_in;
   logic          a_rows_zero_ff, a_rows_zero_in;
   logic [P-1:0]  a_pop_ff, a_pop_in;

   always_comb begin
      a_valid_in     = in_valid;
      a_n_in         = (nulls <= rows) ? rows - nulls : '0;
      a_d_in         = (distinct > a_n_in) ? a_n_in : distinct;
      a_f1_in        = (singletons > a_d_in) ? a_d_in : singletons;
      a_w_in         = (weight == '0) ? W'(1) : weight;
      a_w_one_in     = (weight <= W'(1));
      a_rows_zero_in = (rows == '0);
      a_pop_in       = pop;
   end

   // Stage B: products of the sample counts.
   logic            b_valid_ff;
   logic [WN_W-1:0] b_wn_ff, b_wn_in;
   logic [NDW-1:0]  b_nd_ff, b_nd_in;
   logic [NDW-1:0]  b_f1n_ff, b_f1n_in;
   logic [S-1:0]    b_nmf_ff, b_nmf_in;
   logic [S-1:0]    b_d_ff;
   logic [S-1:0]    b_f1_ff;
   logic            b_n_zero_ff, b_n_zero_in;
   logic            b_rows_zero_ff;
   logic            b_w_one_ff;
   logic [P-1:0]    b_pop_ff;

   always_comb begin
      b_wn_in     = WN_W'(a_w_ff) * WN_W'(a_n_ff);
      b_nd_in     = NDW'(a_n_ff) * NDW'(a_d_ff);
      b_f1n_in    = NDW'(a_f1_ff) * NDW'(a_n_ff);
      b_nmf_in    = a_n_ff - a_f1_ff;
      b_n_zero_in = (a_n_ff == '0);
   end

   // Stage C: population count and case.
   ctl_type         c_ctl_ff, c_ctl_in;
   logic [P-1:0]    c_big_n_ff, c_big_n_in;
   logic [S-1:0]    c_d_ff;
   logic [NDW-1:0]  c_nd_ff;
   logic [NDW-1:0]  c_f1n_ff;
   logic [S-1:0]    c_nmf_ff;
   logic [EXT_W-1:0] wn_x;
   logic [CMP_W-1:0] d_x, n_x;

   always_comb begin
      wn_x = EXT_W'(b_wn_ff);
      if (b_pop_ff != '0) begin
         c_big_n_in = b_pop_ff;
      end else if (wn_x > EXT_W'(POP_MAX)) begin
         c_big_n_in = POP_MAX;
      end else begin
         c_big_n_in = wn_x[P-1:0];
      end
      d_x = CMP_W'(b_d_ff);
      n_x = CMP_W'(c_big_n_in);
      c_ctl_in.valid = b_valid_ff;
      if (b_rows_zero_ff || b_n_zero_ff || (b_d_ff == '0) || (c_big_n_in == '0)) begin
         c_ctl_in.code = CASE_INVALID;
      end else if (b_w_one_ff && (d_x >= n_x)) begin
         c_ctl_in.code = CASE_FULL_COVER;
      end else if (b_f1_ff == b_d_ff) begin
         c_ctl_in.code = CASE_ALL_SINGLE;
      end else if (b_f1_ff == '0) begin
         c_ctl_in.code = CASE_NO_SINGLE;
      end else begin
         c_ctl_in.code = CASE_ESTIMATOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_ctl_ff   <= '0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_ctl_ff   <= c_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_n_ff         <= a_n_in;
         a_d_ff         <= a_d_in;
         a_f1_ff        <= a_f1_in;
         a_w_ff         <= a_w_in;
         a_w_one_ff     <= a_w_one_in;
         a_rows_zero_ff <= a_rows_zero_in;
         a_pop_ff       <= a_pop_in;

         b_wn_ff        <= b_wn_in;
         b_nd_ff        <= b_nd_in;
         b_f1n_ff       <= b_f1n_in;
         b_nmf_ff       <= b_nmf_in;
         b_d_ff         <= a_d_ff;
         b_f1_ff        <= a_f1_ff;
         b_n_zero_ff    <= b_n_zero_in;
         b_rows_zero_ff <= a_rows_zero_ff;
         b_w_one_ff     <= a_w_one_ff;
         b_pop_ff       <= a_pop_ff;

         c_big_n_ff     <= c_big_n_in;
         c_d_ff         <= b_d_ff;
         c_nd_ff        <= b_nd_ff;
         c_f1n_ff       <= b_f1n_ff;
         c_nmf_ff       <= b_nmf_ff;
      end
   end

   assign ctl_o   = c_ctl_ff;
   assign big_n_o = c_big_n_ff;
   assign d_o     = c_d_ff;
   assign nd_o    = c_nd_ff;
   assign nmf_o   = c_nmf_ff;
   assign f1n_o   = c_f1n_ff;

endmodule

// ----- design/dve_mul.sv -----
// ----------------------------------------------------------------------------
// dve_mul: numerator and denominator of the estimator
// Four stages: split partial products, partial sums, full sums, and finally
// the rounded dividend 2*num + den and the divisor 2*den.
// ----------------------------------------------------------------------------
module dve_mul #(
   parameter int SAMPLE_BITS = dve_pkg::SAMPLE_BITS_DEF,
   parameter int POP_BITS    = dve_pkg::POP_BITS_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 advance,
   input  dve_pkg::ctl_type                                     ctl_i,
   input  logic [POP_BITS-1:0]                                  big_n_i,
   input  logic [SAMPLE_BITS-1:0]                               d_i,
   input  logic [2*SAMPLE_BITS-1:0]                             nd_i,
   input  logic [SAMPLE_BITS-1:0]                               nmf_i,
   input  logic [2*SAMPLE_BITS-1:0]                             f1n_i,
   output dve_pkg::ctl_type                                     ctl_o,
   output logic [POP_BITS-1:0]                                  big_n_o,
   output logic [SAMPLE_BITS-1:0]                               d_o,
   output logic [2*SAMPLE_BITS+POP_BITS+1:0]                    dividend_o,
   output logic [dve_pkg::den_bits(SAMPLE_BITS, POP_BITS):0]    divisor_o
);
   import dve_pkg::*;

   localparam int S     = SAMPLE_BITS;
   localparam int P     = POP_BITS;
   localparam int NDW   = 2 * S;
   localparam int H     = (P + 1) / 2;
   localparam int HI    = P - H;
   localparam int PH_W  = S + HI;
   localparam int PL_W  = S + H;
   localparam int NUM_W = 2 * S + P;
   localparam int DEN_W = den_bits(S, P);
   localparam int DVD_W = NUM_W + 2;
   localparam int DVS_W = DEN_W + 1;
   localparam int DEPTH = 4;

   // Side data shift line, one entry per stage.
   ctl_type       ctl_ff [DEPTH];
   logic [P-1:0]  n_ff   [DEPTH];
   logic [S-1:0]  d_ff   [DEPTH];

   // Stage D: partial products, each at most SAMPLE_BITS by half of POP_BITS, rounded up.
   logic [PH_W-1:0]  d_hh_ff, d_hh_in;
   logic [PL_W-1:0]  d_hl_ff, d_hl_in;
   logic [PH_W-1:0]  d_lh_ff, d_lh_in;
   logic [PL_W-1:0]  d_ll_ff, d_ll_in;
   logic [PH_W-1:0]  d_mh_ff, d_mh_in;
   logic [PL_W-1:0]  d_ml_ff, d_ml_in;
   logic [NDW-1:0]   d_f1n_ff;

   always_comb begin
      d_hh_in = PH_W'(nd_i[NDW-1:S]) * PH_W'(big_n_i[P-1:H]);
      d_hl_in = PL_W'(nd_i[NDW-1:S]) * PL_W'(big_n_i[H-1:0]);
      d_lh_in = PH_W'(nd_i[S-1:0])   * PH_W'(big_n_i[P-1:H]);
      d_ll_in = PL_W'(nd_i[S-1:0])   * PL_W'(big_n_i[H-1:0]);
      d_mh_in = PH_W'(nmf_i)         * PH_W'(big_n_i[P-1:H]);
      d_ml_in = PL_W'(nmf_i)         * PL_W'(big_n_i[H-1:0]);
   end

   // Stage E: partial sums.
   logic [NUM_W-1:0] e_num_a_ff, e_num_a_in;
   logic [NUM_W-1:0] e_num_b_ff, e_num_b_in;
   logic [DEN_W-1:0] e_den_a_ff, e_den_a_in;
   logic [DEN_W-1:0] e_den_b_ff, e_den_b_in;

   always_comb begin
      e_num_a_in = (NUM_W'(d_hh_ff) << (S + H)) + (NUM_W'(d_hl_ff) << S);
      e_num_b_in = (NUM_W'(d_lh_ff) << H) + NUM_W'(d_ll_ff);
      e_den_a_in = (DEN_W'(d_mh_ff) << H) + DEN_W'(d_ml_ff);
      e_den_b_in = DEN_W'(d_f1n_ff);
   end

   // Stage F: full numerator n*d*N and denominator (n-f1)*N + f1*n.
   logic [NUM_W-1:0] f_num_ff, f_num_in;
   logic [DEN_W-1:0] f_den_ff, f_den_in;

   always_comb begin
      f_num_in = e_num_a_ff + e_num_b_ff;
      f_den_in = e_den_a_ff + e_den_b_ff;
   end

   // Stage G: round half up by dividing (2*num + den) by 2*den.
   logic [DVD_W-1:0] g_dividend_ff, g_dividend_in;
   logic [DVS_W-1:0] g_divisor_ff, g_divisor_in;

   always_comb begin
      g_dividend_in = (DVD_W'(f_num_ff) << 1) + DVD_W'(f_den_ff);
      g_divisor_in  = DVS_W'(f_den_ff) << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (advance) begin
         ctl_ff[0] <= ctl_i;
         for (int i = 1; i < DEPTH; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff[0] <= big_n_i;
         d_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) begin
            n_ff[i] <= n_ff[i-1];
            d_ff[i] <= d_ff[i-1];
         end
         d_hh_ff       <= d_hh_in;
         d_hl_ff       <= d_hl_in;
         d_lh_ff       <= d_lh_in;
         d_ll_ff       <= d_ll_in;
         d_mh_ff       <= d_mh_in;
         d_ml_ff       <= d_ml_in;
         d_f1n_ff      <= f1n_i;
         e_num_a_ff    <= e_num_a_in;
         e_num_b_ff    <= e_num_b_in;
         e_den_a_ff    <= e_den_a_in;
         e_den_b_ff    <= e_den_b_in;
         f_num_ff      <= f_num_in;
         f_den_ff      <= f_den_in;
         g_dividend_ff <= g_dividend_in;
         g_divisor_ff  <= g_divisor_in;
      end
   end

   assign ctl_o      = ctl_ff[DEPTH-1];
   assign big_n_o    = n_ff[DEPTH-1];
   assign d_o        = d_ff[DEPTH-1];
   assign dividend_o = g_dividend_ff;
   assign divisor_o  = g_divisor_ff;

endmodule

// ----- design/dve_div_cell.sv -----
// ----------------------------------------------------------------------------
// dve_div_cell: one step of the restoring divider chain
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit into the low word.
// ----------------------------------------------------------------------------
module dve_div_cell #(
   parameter int SAMPLE_BITS = dve_pkg::SAMPLE_BITS_DEF,
   parameter int POP_BITS    = dve_pkg::POP_BITS_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 advance,
   input  dve_pkg::ctl_type                                     ctl_i,
   input  logic [dve_pkg::den_bits(SAMPLE_BITS, POP_BITS):0]    rem_i,
   input  logic [2*SAMPLE_BITS-1:0]                             low_i,
   input  logic [dve_pkg::den_bits(SAMPLE_BITS, POP_BITS):0]    divisor_i,
   input  logic [POP_BITS-1:0]                                  big_n_i,
   input  logic [SAMPLE_BITS-1:0]                               d_i,
   output dve_pkg::ctl_type                                     ctl_o,
   output logic [dve_pkg::den_bits(SAMPLE_BITS, POP_BITS):0]    rem_o,
   output logic [2*SAMPLE_BITS-1:0]                             low_o,
   output logic [dve_pkg::den_bits(SAMPLE_BITS, POP_BITS):0]    divisor_o,
   output logic [POP_BITS-1:0]                                  big_n_o,
   output logic [SAMPLE_BITS-1:0]                               d_o
);
   import dve_pkg::*;

   localparam int REM_W = den_bits(SAMPLE_BITS, POP_BITS) + 1;
   localparam int Q_W   = 2 * SAMPLE_BITS;

   ctl_type                 ctl_ff;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [Q_W-1:0]          low_ff, low_in;
   logic [REM_W-1:0]        divisor_ff;
   logic [POP_BITS-1:0]     big_n_ff;
   logic [SAMPLE_BITS-1:0]  d_ff;
   logic [REM_W:0]          trial;
   logic [REM_W:0]          diff;
   logic                    fits;

   always_comb begin
      trial  = {rem_i, low_i[Q_W-1]};
      diff   = trial - {1'b0, divisor_i};
      fits   = (trial >= {1'b0, divisor_i});
      rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      low_in = {low_i[Q_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff     <= rem_in;
         low_ff     <= low_in;
         divisor_ff <= divisor_i;
         big_n_ff   <= big_n_i;
         d_ff       <= d_i;
      end
   end

   assign ctl_o     = ctl_ff;
   assign rem_o     = rem_ff;
   assign low_o     = low_ff;
   assign divisor_o = divisor_ff;
   assign big_n_o   = big_n_ff;
   assign d_o       = d_ff;

endmodule

// ----- design/distinct_value_estimator_top.sv -----
// ----------------------------------------------------------------------------
// distinct_value_estimator_top: distinct value estimate from sample counts
// Each input transfer carries one column's sample statistics and yields
// exactly one result transfer with the estimated count of distinct non-null
// values in the table and a code for the case that decided it. The block is
// a pipeline that takes one transfer in every clock cycle while the output
// register is free or being read, and it returns results in order: the front
// end decodes the counts and picks the case, the multiplier forms the
// numerator and denominator of the estimator from split partial products, a
// chain of 2*SAMPLE_BITS divider cells produces one quotient bit per cycle,
// and the result is clamped into the output register. When a result sits
// in the output register and is not taken, the whole pipeline holds and
// req_ready goes low; it rises again in the cycle in which the result is
// taken. The estimate is exact integer arithmetic, rounded half up.
// ----------------------------------------------------------------------------
module distinct_value_estimator_top #(
   parameter int SAMPLE_BITS = dve_pkg::SAMPLE_BITS_DEF,
   parameter int POP_BITS    = dve_pkg::POP_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [SAMPLE_BITS-1:0]            req_rows_sampled,
   input  logic [SAMPLE_BITS-1:0]            req_nulls_sampled,
   input  logic [SAMPLE_BITS-1:0]            req_distinct_sampled,
   input  logic [SAMPLE_BITS-1:0]            req_singletons_sampled,
   input  logic [dve_pkg::WEIGHT_BITS-1:0]   req_expansion_weight,
   input  logic [POP_BITS-1:0]               req_population_nonnull,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [POP_BITS-1:0]               rsp_distinct_estimate,
   output logic [dve_pkg::CASE_BITS-1:0]     rsp_case_taken
);
   import dve_pkg::*;

   localparam int S     = SAMPLE_BITS;
   localparam int P     = POP_BITS;
   localparam int Q_W   = 2 * S;
   localparam int NUM_W = 2 * S + P;
   localparam int DVD_W = NUM_W + 2;
   localparam int REM_W = den_bits(S, P) + 1;
   localparam int CMP_W = max_int(Q_W, P);

   // The pipeline moves whenever the output register is free or being read.
   logic rsp_valid_ff;
   logic advance;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Front end outputs.
   ctl_type           fe_ctl;
   logic [P-1:0]      fe_big_n;
   logic [S-1:0]      fe_d;
   logic [2*S-1:0]    fe_nd;
   logic [S-1:0]      fe_nmf;
   logic [2*S-1:0]    fe_f1n;

   dve_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .POP_BITS    (POP_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .rows       (req_rows_sampled),
      .nulls      (req_nulls_sampled),
      .distinct   (req_distinct_sampled),
      .singletons (req_singletons_sampled),
      .weight     (req_expansion_weight),
      .pop        (req_population_nonnull),
      .ctl_o      (fe_ctl),
      .big_n_o    (fe_big_n),
      .d_o        (fe_d),
      .nd_o       (fe_nd),
      .nmf_o      (fe_nmf),
      .f1n_o      (fe_f1n)
   );

   // Multiplier outputs.
   ctl_type           mu_ctl;
   logic [P-1:0]      mu_big_n;
   logic [S-1:0]      mu_d;
   logic [DVD_W-1:0]  mu_dividend;
   logic [REM_W-1:0]  mu_divisor;

   dve_mul #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .POP_BITS    (POP_BITS)
   ) u_mul (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ctl_i      (fe_ctl),
      .big_n_i    (fe_big_n),
      .d_i        (fe_d),
      .nd_i       (fe_nd),
      .nmf_i      (fe_nmf),
      .f1n_i      (fe_f1n),
      .ctl_o      (mu_ctl),
      .big_n_o    (mu_big_n),
      .d_o        (mu_d),
      .dividend_o (mu_dividend),
      .divisor_o  (mu_divisor)
   );

   // Divider chain. Entry zero holds the top dividend bits as the starting
   // remainder and the low quotient-width bits still to be shifted in; after
   // the last cell the low word holds the quotient.
   ctl_type           ctl_ch [Q_W+1];
   logic [REM_W-1:0]  rem_ch [Q_W+1];
   logic [Q_W-1:0]    low_ch [Q_W+1];
   logic [REM_W-1:0]  dvs_ch [Q_W+1];
   logic [P-1:0]      n_ch   [Q_W+1];
   logic [S-1:0]      d_ch   [Q_W+1];

   assign ctl_ch[0] = mu_ctl;
   assign rem_ch[0] = REM_W'(mu_dividend[DVD_W-1:Q_W]);
   assign low_ch[0] = mu_dividend[Q_W-1:0];
   assign dvs_ch[0] = mu_divisor;
   assign n_ch[0]   = mu_big_n;
   assign d_ch[0]   = mu_d;

   for (genvar k = 0; k < Q_W; k++) begin : g_cell
      dve_div_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .POP_BITS    (POP_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .ctl_i     (ctl_ch[k]),
         .rem_i     (rem_ch[k]),
         .low_i     (low_ch[k]),
         .divisor_i (dvs_ch[k]),
         .big_n_i   (n_ch[k]),
         .d_i       (d_ch[k]),
         .ctl_o     (ctl_ch[k+1]),
         .rem_o     (rem_ch[k+1]),
         .low_o     (low_ch[k+1]),
         .divisor_o (dvs_ch[k+1]),
         .big_n_o   (n_ch[k+1]),
         .d_o       (d_ch[k+1])
      );
   end

   // Output stage: the estimator quotient is clamped to at least the sample
   // distinct count and then to at most the population count. The other
   // cases pick their fixed answer here.
   logic [P-1:0]     est_ff, est_in;
   case_type         code_ff;
   logic [CMP_W-1:0] q_x, d_x, n_x, lo_x;
   logic [P-1:0]     est_q, d_min;

   always_comb begin
      q_x   = CMP_W'(low_ch[Q_W]);
      d_x   = CMP_W'(d_ch[Q_W]);
      n_x   = CMP_W'(n_ch[Q_W]);
      lo_x  = (q_x < d_x) ? d_x : q_x;
      est_q = (lo_x > n_x) ? n_ch[Q_W] : lo_x[P-1:0];
      d_min = (d_x < n_x) ? d_x[P-1:0] : n_ch[Q_W];
      unique case (ctl_ch[Q_W].code) inside
         CASE_INVALID:                     est_in = P'(1);
         CASE_FULL_COVER, CASE_ALL_SINGLE: est_in = n_ch[Q_W];
         CASE_NO_SINGLE:                   est_in = d_min;
         CASE_ESTIMATOR:                   est_in = est_q;
         default:                          est_in = P'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl_ch[Q_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         est_ff  <= est_in;
         code_ff <= ctl_ch[Q_W].code;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_distinct_estimate = est_ff;
   assign rsp_case_taken        = code_ff;

`ifndef ASSERT_OFF
   // An estimator item must enter the divider with a quotient that fits.
   a_div_entry_fits: assert property (@(posedge clock) disable iff (reset)
      (ctl_ch[0].valid && (ctl_ch[0].code == CASE_ESTIMATOR))
         |-> (rem_ch[0] < dvs_ch[0]))
      else $error("divider entry remainder not below divisor");

   // An estimator item leaves the last step with a remainder below the divisor.
   a_div_exit_fits: assert property (@(posedge clock) disable iff (reset)
      (ctl_ch[Q_W].valid && (ctl_ch[Q_W].code == CASE_ESTIMATOR))
         |-> (rem_ch[Q_W] < dvs_ch[Q_W]))
      else $error("divider exit remainder not below divisor");

   a_est_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distinct_estimate != '0))
      else $error("estimate below one");

   a_invalid_is_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_case_taken == CASE_INVALID)) |-> (rsp_distinct_estimate == P'(1)))
      else $error("invalid case with estimate other than one");

   // A stalled output must freeze the control word at the end of the divider chain.
   a_stall_holds_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(ctl_ch[Q_W]))
      else $error("divider chain moved during output stall");
`endif

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for distinct_value_estimator_top
// Sends directed and random column statistics through the request channel
// with random source gaps and sink stalls, predicts each estimate and case
// code independently, and checks every result in order against it.
// ----------------------------------------------------------------------------
module tb_top;
   import dve_pkg::*;

   localparam int SB = SAMPLE_BITS_DEF;
   localparam int PB = POP_BITS_DEF;
   localparam int RANDOM_ITEMS = 1400;
   // No new gaps or stalls start in the tail of the run.
   localparam int TAIL_ITEMS = 150;
   // The drain wait covers the pipeline latency with margin.
   localparam int DRAIN_CYCLES = 2 * SB + 20;
   // The slowest correct run never goes this long without a transfer: the limit
   // covers the latency plus a full source gap plus a full sink stall.
   localparam int QUIET_LIMIT = 2000;
   localparam logic [63:0] SAMPLE_MAX = (64'd1 << SB) - 64'd1;
   localparam logic [63:0] POP_FIELD_MAX = (64'd1 << PB) - 64'd1;
   localparam logic [127:0] POP_MAX = (128'd1 << PB) - 128'd1;

   // One column's sample statistics, as carried by one request transfer.
   typedef struct {
      logic [SB-1:0]          rows;
      logic [SB-1:0]          nulls;
      logic [SB-1:0]          distinct;
      logic [SB-1:0]          singles;
      logic [WEIGHT_BITS-1:0] weight;
      logic [PB-1:0]          pop;
   } column_stats_type;

   typedef struct {
      logic [PB-1:0] estimate;
      case_type      code;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SB-1:0]          req_rows_sampled = '0;
   logic [SB-1:0]          req_nulls_sampled = '0;
   logic [SB-1:0]          req_distinct_sampled = '0;
   logic [SB-1:0]          req_singletons_sampled = '0;
   logic [WEIGHT_BITS-1:0] req_expansion_weight = '0;
   logic [PB-1:0]          req_population_nonnull = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PB-1:0]          rsp_distinct_estimate;
   logic [CASE_BITS-1:0]   rsp_case_taken;

   column_stats_type pending_stats[$];
   estimate_type     expected_estimates[$];
   column_stats_type driven_stats;

   int errors = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int case_hits[5] = '{default: 0};
   int quiet_cycles = 0;

   distinct_value_estimator_top #(
      .SAMPLE_BITS(SB),
      .POP_BITS(PB)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rows_sampled(req_rows_sampled),
      .req_nulls_sampled(req_nulls_sampled),
      .req_distinct_sampled(req_distinct_sampled),
      .req_singletons_sampled(req_singletons_sampled),
      .req_expansion_weight(req_expansion_weight),
      .req_population_nonnull(req_population_nonnull),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_distinct_estimate(rsp_distinct_estimate),
      .rsp_case_taken(rsp_case_taken)
   );

   always #10 clock = ~clock;

   // Works out the estimate and case code for one set of sample counts. All
   // arithmetic is done on 128-bit vectors, wide enough for n*d*N exactly.
   function automatic estimate_type predict_estimate(input column_stats_type s);
      logic [127:0] n, d, f1, w, big_n, num, den, q;
      estimate_type r;
      n = (s.nulls <= s.rows) ? 128'(s.rows - s.nulls) : 128'd0;
      d = 128'(s.distinct);
      f1 = 128'(s.singles);
      w = (s.weight == '0) ? 128'd1 : 128'(s.weight);
      if (s.pop != '0) begin
         big_n = 128'(s.pop);
      end else begin
         big_n = w * n;
         if (big_n > POP_MAX) begin
            big_n = POP_MAX;
         end
      end
      r.estimate = PB'(1);
      r.code = CASE_INVALID;
      if (s.rows != '0 && n != 0 && d != 0 && big_n != 0) begin
         // The distinct count cannot exceed the non-null rows, nor the
         // singletons the distinct count.
         if (d > n) begin
            d = n;
         end
         if (f1 > d) begin
            f1 = d;
         end
         if (w == 1 && d >= big_n) begin
            r.estimate = big_n[PB-1:0];
            r.code = CASE_FULL_COVER;
         end else if (f1 == d) begin
            r.estimate = big_n[PB-1:0];
            r.code = CASE_ALL_SINGLE;
         end else if (f1 == 0) begin
            r.estimate = (d < big_n) ? d[PB-1:0] : big_n[PB-1:0];
            r.code = CASE_NO_SINGLE;
         end else begin
            // Rounding half up: floor((2*num + den) / (2*den)).
            num = n * d * big_n;
            den = (n - f1) * big_n + f1 * n;
            q = (2 * num + den) / (2 * den);
            if (q < d) begin
               q = d;
            end
            if (q > big_n) begin
               q = big_n;
            end
            r.estimate = q[PB-1:0];
            r.code = CASE_ESTIMATOR;
         end
      end
      return r;
   endfunction

   function automatic column_stats_type make_stats(input logic [63:0] rows, nulls,
                                                   distinct, singles, weight, pop);
      column_stats_type s;
      s.rows = rows[SB-1:0];
      s.nulls = nulls[SB-1:0];
      s.distinct = distinct[SB-1:0];
      s.singles = singles[SB-1:0];
      s.weight = weight[WEIGHT_BITS-1:0];
      s.pop = pop[PB-1:0];
      return s;
   endfunction

   // A value of random width, so that small and large magnitudes are equally
   // likely in a logarithmic sense.
   function automatic logic [63:0] random_of_width(input int max_width);
      int w;
      logic [63:0] v;
      w = $urandom_range(0, max_width);
      v = {$urandom, $urandom};
      if (w == 0) begin
         return 64'd0;
      end
      return v & ((64'd1 << w) - 64'd1);
   endfunction

   function automatic column_stats_type random_stats();
      column_stats_type s;
      logic [63:0] n, d, f1;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         // Pure noise: every bit of every field random.
         s = make_stats(64'($urandom), 64'($urandom), 64'($urandom), 64'($urandom),
                        64'($urandom), {$urandom, $urandom});
      end else if (kind == 1) begin
         // Unrelated counts of random magnitude, mostly inconsistent.
         s = make_stats(random_of_width(SB), random_of_width(SB), random_of_width(SB),
                        random_of_width(SB), random_of_width(WEIGHT_BITS),
                        random_of_width(PB));
      end else begin
         // Mostly consistent sample statistics with random content.
         s.rows = SB'(random_of_width(SB));
         if (s.rows == '0) begin
            s.rows = SB'(1);
         end
         s.nulls = ($urandom_range(0, 2) == 0) ? '0 :
                   SB'($urandom_range(0, 32'(s.rows - 1'b1)));
         n = 64'(s.rows - s.nulls);
         case ($urandom_range(0, 3))
            0: d = n;
            1: d = 64'($urandom_range(1, 32'(n)));
            default: d = (random_of_width(SB) % n) + 1;
         endcase
         if ($urandom_range(0, 19) == 0) begin
            d = random_of_width(SB);
         end
         case ($urandom_range(0, 5))
            0: f1 = 0;
            1: f1 = d;
            2: f1 = 1;
            3: f1 = d - 1;
            default: f1 = 64'($urandom_range(0, 32'(d)));
         endcase
         if ($urandom_range(0, 19) == 0) begin
            f1 = d + random_of_width(8);
         end
         s.distinct = d[SB-1:0];
         s.singles = f1[SB-1:0];
         case ($urandom_range(0, 3))
            0: s.weight = '0;
            1: s.weight = WEIGHT_BITS'(1);
            2: s.weight = WEIGHT_BITS'(random_of_width(6));
            default: s.weight = WEIGHT_BITS'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0, 1: s.pop = '0;
            2: s.pop = PB'(random_of_width(PB));
            default: s.pop = PB'($urandom_range(1, 32'(d + 1)));
         endcase
      end
      return s;
   endfunction

   // Driver: presents the next pending item whenever the channel is free and no
   // random gap is running, holding valid and payload steady until the transfer happens.
   int send_gap = 0;
   bit send_idling_on = 1'b1;

   always @(posedge clock) begin : drive_proc
      column_stats_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_estimates.push_back(predict_estimate(driven_stats));
            requests_sent++;
            // Switch between idling and back-to-back stretches now and then.
            if (requests_sent % 50 == 0) begin
               send_idling_on = ($urandom_range(0, 3) != 0);
            end
         end
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && send_idling_on && pending_stats.size() > TAIL_ITEMS &&
                $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 14);
            end
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_stats.size() > 0) begin
               s = pending_stats.pop_front();
               driven_stats = s;
               req_rows_sampled <= s.rows;
               req_nulls_sampled <= s.nulls;
               req_distinct_sampled <= s.distinct;
               req_singletons_sampled <= s.singles;
               req_expansion_weight <= s.weight;
               req_population_nonnull <= s.pop;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest prediction and
   // drives the sink side with random stall bursts.
   int recv_stall = 0;
   bit recv_stalls_on = 1'b1;

   always @(posedge clock) begin : check_proc
      estimate_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_estimates.size() == 0) begin
               $error("result transfer with no request outstanding: estimate %0d case %0d",
                      rsp_distinct_estimate, rsp_case_taken);
               errors++;
            end else begin
               want = expected_estimates.pop_front();
               results_checked++;
               case_hits[int'(want.code)]++;
               if (rsp_distinct_estimate !== want.estimate) begin
                  $error("distinct_estimate: expected %0d, got %0d",
                         want.estimate, rsp_distinct_estimate);
                  errors++;
               end
               if (rsp_case_taken !== want.code) begin
                  $error("case_taken: expected %0d, got %0d", want.code, rsp_case_taken);
                  errors++;
               end
               if (results_checked % 50 == 0) begin
                  recv_stalls_on = ($urandom_range(0, 3) != 0);
               end
            end
         end
         if (recv_stall == 0 && recv_stalls_on && pending_stats.size() > TAIL_ITEMS &&
             $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(1, 14);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: a long run of cycles without any transfer means the block hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_estimates.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : main_proc
      // Invalid inputs: empty sample, all nulls, nulls above rows, no values.
      pending_stats.push_back(make_stats(0, 0, 0, 0, 0, 0));
      pending_stats.push_back(make_stats(10, 10, 5, 1, 3, 0));
      pending_stats.push_back(make_stats(5, 9, 3, 1, 2, 0));
      pending_stats.push_back(make_stats(100, 0, 0, 0, 4, 0));
      pending_stats.push_back(make_stats(SAMPLE_MAX, SAMPLE_MAX, 7, 2, 5, 0));
      // Every field at its maximum, and again with no nulls; singletons equal the distinct count.
      pending_stats.push_back(make_stats(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                                         16'hFFFF, POP_FIELD_MAX));
      pending_stats.push_back(make_stats(SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MAX,
                                         16'hFFFF, POP_FIELD_MAX));
      // Full coverage with weight one, weight zero and an explicit population.
      pending_stats.push_back(make_stats(100, 0, 100, 3, 1, 0));
      pending_stats.push_back(make_stats(100, 0, 100, 3, 0, 0));
      pending_stats.push_back(make_stats(100, 0, 80, 10, 1, 50));
      pending_stats.push_back(make_stats(1, 0, 1, 0, 0, 0));
      // Weight above one keeps full coverage out even when d reaches n.
      pending_stats.push_back(make_stats(100, 0, 100, 40, 2, 0));
      // All singletons, and singletons above d clamped down to it.
      pending_stats.push_back(make_stats(1000, 0, 500, 500, 10, 0));
      pending_stats.push_back(make_stats(1000, 0, 200, 900, 10, 0));
      // Distinct count above the non-null rows is clamped to them.
      pending_stats.push_back(make_stats(50, 10, 100, 5, 4, 0));
      // No singletons: d below N and N below d.
      pending_stats.push_back(make_stats(1000, 0, 300, 0, 8, 0));
      pending_stats.push_back(make_stats(1000, 0, 300, 0, 3, 100));
      pending_stats.push_back(make_stats(1000, 0, 300, 0, 1, 5000));
      // Estimator clamped down to a small population.
      pending_stats.push_back(make_stats(200, 0, 100, 50, 2, 5));
      // Estimator exactly halfway between two integers: 3.5 rounds to 4.
      pending_stats.push_back(make_stats(2, 0, 2, 1, 7, 14));
      // Largest derived population and largest explicit population.
      pending_stats.push_back(make_stats(SAMPLE_MAX, 0, 1000, 1, 16'hFFFF, 0));
      pending_stats.push_back(make_stats(SAMPLE_MAX, 0, SAMPLE_MAX, 1, 0, POP_FIELD_MAX));
      pending_stats.push_back(make_stats(SAMPLE_MAX, 0, SAMPLE_MAX - 1, SAMPLE_MAX - 2,
                                         16'hFFFF, 0));
      repeat (RANDOM_ITEMS) begin
         pending_stats.push_back(random_stats());
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_stats.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_estimates.size() != 0) begin
         @(posedge clock);
      end
      // Give any stray result time to show up after the last expected one.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d estimates from %0d requests under random gaps and stalls.",
               results_checked, requests_sent);
      $display("Cases: invalid %0d, full coverage %0d, all singletons %0d, %s %0d, %s %0d.",
               case_hits[0], case_hits[1], case_hits[2], "no singletons", case_hits[3],
               "estimator", case_hits[4]);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/dve_pkg.sv
design/dve_front.sv
design/dve_mul.sv
design/dve_div_cell.sv
design/distinct_value_estimator_top.sv
bench/tb_top.sv
